// ===== hw/rtl/bmrh_pkg.sv =====
package bmrh_pkg;

  localparam int unsigned CNT_W       = 32;
  localparam int unsigned HIST_BINS   = 4096;
  localparam int unsigned BIN_W       = $clog2(HIST_BINS);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] HIST_BINS_CW = CNT_W'(HIST_BINS);

  typedef enum logic [0:0] {
    FUNC_COMPARE = 1'b0,
    FUNC_READ    = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    BASE_A    = 3'd0,
    BASE_C    = 3'd1,
    BASE_G    = 3'd2,
    BASE_T    = 3'd3,
    BASE_NONE = 3'd4
  } base_t;

  // One classified word handed from the front end to the histogram engine.
  typedef struct packed {
    logic             is_read;
    logic             pair_matches;
    logic [CNT_W-1:0] match_mismatches;
    logic [CNT_W-1:0] total_bases;
    logic [CNT_W-1:0] total_mismatches;
    logic [BIN_W-1:0] bin_addr;
    logic             bin_inc;
    logic [1:0]       bin0_inc;
  } job_t;

  // Back-pressure seen by the front end.
  typedef struct packed {
    logic q_full;
    logic clearing;
  } hold_t;

  function automatic base_t base_code(input logic [7:0] letter);
    base_t code;
    unique case (letter) inside
      8'h41, 8'h61: code = BASE_A;
      8'h43, 8'h63: code = BASE_C;
      8'h47, 8'h67: code = BASE_G;
      8'h54, 8'h74: code = BASE_T;
      default:      code = BASE_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/bmrh_front.sv =====
module bmrh_front
  import bmrh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [7:0]       in_letter_a,
  input  logic [7:0]       in_letter_b,
  input  logic             in_end_of_match,
  input  logic [BIN_W-1:0] in_bin_index,
  input  hold_t            hold,
  output logic             push,
  output job_t             push_job
);

  logic [CNT_W-1:0] run_length_r, base_total_r, mismatch_total_r, mismatch_in_match_r;
  logic [CNT_W-1:0] run_length_nxt, base_total_nxt, mismatch_total_nxt;
  logic [CNT_W-1:0] mismatch_in_match_nxt;
  logic [CNT_W-1:0] run_after, mim_after, add_len;
  base_t            code_a, code_b;
  logic             is_read, is_match, add_vld, in_range;

  assign in_stall = hold.q_full || hold.clearing;
  assign push     = in_valid && !in_stall;
  assign is_read  = (func_t'(in_func) == FUNC_READ);

  always_comb begin
    code_a    = base_code(in_letter_a);
    code_b    = base_code(in_letter_b);
    is_match  = (code_a != BASE_NONE) && (code_a == code_b);
    run_after = is_match ? sat_inc(run_length_r) : '0;
    mim_after = is_match ? mismatch_in_match_r : sat_inc(mismatch_in_match_r);
    // A mismatch closes the old run; a clean end of match closes the grown run.
    // A mismatch on the last pair also closes an empty run, which lands in bin 0.
    add_len   = is_match ? run_after : run_length_r;
    add_vld   = !is_match || in_end_of_match;
    in_range  = (add_len != '0) && (add_len < HIST_BINS_CW);

    base_total_nxt        = sat_inc(base_total_r);
    mismatch_total_nxt    = is_match ? mismatch_total_r : sat_inc(mismatch_total_r);
    run_length_nxt        = in_end_of_match ? '0 : run_after;
    mismatch_in_match_nxt = in_end_of_match ? '0 : mim_after;

    push_job = '0;
    if (is_read) begin
      push_job.is_read          = 1'b1;
      push_job.match_mismatches = mismatch_in_match_r;
      push_job.total_bases      = base_total_r;
      push_job.total_mismatches = mismatch_total_r;
      push_job.bin_addr         = in_bin_index;
    end else begin
      push_job.pair_matches     = is_match;
      push_job.match_mismatches = mim_after;
      push_job.total_bases      = base_total_nxt;
      push_job.total_mismatches = mismatch_total_nxt;
      push_job.bin_addr         = add_len[BIN_W-1:0];
      push_job.bin_inc          = add_vld && in_range;
      push_job.bin0_inc         = {1'b0, add_vld && !in_range}
                                + {1'b0, !is_match && in_end_of_match};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_length_r        <= '0;
      base_total_r        <= '0;
      mismatch_total_r    <= '0;
      mismatch_in_match_r <= '0;
    end else if (push && !is_read) begin
      run_length_r        <= run_length_nxt;
      base_total_r        <= base_total_nxt;
      mismatch_total_r    <= mismatch_total_nxt;
      mismatch_in_match_r <= mismatch_in_match_nxt;
    end
  end

  a_bin_zero_not_in_ram: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_job.bin_inc |-> push_job.bin_addr != '0)
    else $error("front end sent bin 0 to the histogram RAM");

endmodule

// ===== hw/rtl/bmrh_queue.sv =====
module bmrh_queue
  import bmrh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic head_vld,
  output job_t head_job,
  output logic full
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head_vld = (count_r != '0);
  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("word written into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("word taken from an empty queue");

endmodule

// ===== hw/rtl/bmrh_back.sv =====
module bmrh_back
  import bmrh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_vld,
  input  job_t             head_job,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_pair_matches,
  output logic [CNT_W-1:0] out_match_mismatches,
  output logic [CNT_W-1:0] out_total_bases,
  output logic [CNT_W-1:0] out_total_mismatches,
  output logic [CNT_W-1:0] out_bin_count
);

  logic [CNT_W-1:0] hist_mem [HIST_BINS];

  logic             clr_busy_r;
  logic [BIN_W-1:0] clr_addr_r;

  job_t             s2_job_r;
  logic             s2_vld_r;
  logic [CNT_W-1:0] rd_data_r, fwd_data_r, bin0_r, bin0_nxt;
  logic             hit_r;

  logic             s2_adv, wr_en;
  logic [CNT_W-1:0] bin_cur, wr_data, bin_count;
  logic [CNT_W:0]   bin0_sum;

  assign clearing = clr_busy_r;
  assign s2_adv   = s2_vld_r && (!out_valid || !out_stall);
  assign pop      = head_vld && !clr_busy_r && (!s2_vld_r || s2_adv);

  always_comb begin
    // The RAM read was taken at the same edge as the previous write; forward it.
    bin_cur   = hit_r ? fwd_data_r : rd_data_r;
    wr_data   = sat_inc(bin_cur);
    wr_en     = s2_adv && s2_job_r.bin_inc;
    bin0_sum  = {1'b0, bin0_r} + (CNT_W+1)'(s2_job_r.bin0_inc);
    bin0_nxt  = bin0_sum[CNT_W] ? CNT_MAX : bin0_sum[CNT_W-1:0];
    bin_count = '0;
    if (s2_job_r.is_read) begin
      bin_count = (s2_job_r.bin_addr == '0) ? bin0_r : bin_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      hist_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      hist_mem[s2_job_r.bin_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r  <= hist_mem[head_job.bin_addr];
      hit_r      <= wr_en && (s2_job_r.bin_addr == head_job.bin_addr);
      fwd_data_r <= wr_data;
      s2_job_r   <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s2_vld_r   <= 1'b0;
      bin0_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + BIN_W'(1);
        if (clr_addr_r == {BIN_W{1'b1}}) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (pop) begin
        s2_vld_r <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_r <= 1'b0;
      end
      if (s2_adv) begin
        bin0_r    <= bin0_nxt;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_pair_matches     <= s2_job_r.pair_matches;
      out_match_mismatches <= s2_job_r.match_mismatches;
      out_total_bases      <= s2_job_r.total_bases;
      out_total_mismatches <= s2_job_r.total_mismatches;
      out_bin_count        <= bin_count;
    end
  end

  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s2_vld_r && !pop)
    else $error("histogram engine busy during the clearing pass");

  a_bin0_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> bin0_r >= $past(bin0_r))
    else $error("bin 0 count went down");

endmodule

// ===== hw/rtl/base_mismatch_run_histogram_top.sv =====
// Base mismatch run histogram.
//
// Unless stalled, the input channel takes one word per cycle: with in_func
// low it compares the letters in in_letter_a and in_letter_b, with in_func
// high it reads the histogram bin named by in_bin_index. Every accepted word
// gives exactly one result word on the output channel, in order. A word is
// accepted at a rising edge where its valid is high and its stall is low.
//
// The front end classifies each pair and keeps the running counters, so it
// takes one word every cycle unless held. A four-word queue decouples it
// from the histogram engine, which does one read-modify-write of the bin RAM
// per word and forwards the last written bin to a back-to-back hit on the
// same bin. Bin 0 lives in a register, since a word may add to it twice.
//
// A result goes through the queue, the stage-2 and the output registers to
// out_valid. The sustained rate is one word per cycle while out_stall is low,
// set by the single RAM port pair. After reset the engine zeroes the
// 4096-entry bin RAM, one entry a cycle, and holds in_stall high until done.
// On a receiver stall the output word holds, the queue fills, in_stall rises.
module base_mismatch_run_histogram_top
  import bmrh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [7:0]       in_letter_a,
  input  logic [7:0]       in_letter_b,
  input  logic             in_end_of_match,
  input  logic [BIN_W-1:0] in_bin_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_pair_matches,
  output logic [CNT_W-1:0] out_match_mismatches,
  output logic [CNT_W-1:0] out_total_bases,
  output logic [CNT_W-1:0] out_total_mismatches,
  output logic [CNT_W-1:0] out_bin_count
);

  hold_t hold;
  logic  q_full, clearing;
  logic  push, pop, head_vld;
  job_t  push_job, head_job;

  // The front end stalls on a full queue and during the clearing pass.
  assign hold = '{q_full: q_full, clearing: clearing};

  // Front end: classification and the scalar counters.
  bmrh_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_letter_a     (in_letter_a),
    .in_letter_b     (in_letter_b),
    .in_end_of_match (in_end_of_match),
    .in_bin_index    (in_bin_index),
    .hold            (hold),
    .push            (push),
    .push_job        (push_job)
  );

  bmrh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_vld (head_vld),
    .head_job (head_job),
    .full     (q_full)
  );

  // Back end: histogram RAM, clearing pass and the output register.
  bmrh_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head_vld             (head_vld),
    .head_job             (head_job),
    .pop                  (pop),
    .clearing             (clearing),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pair_matches     (out_pair_matches),
    .out_match_mismatches (out_match_mismatches),
    .out_total_bases      (out_total_bases),
    .out_total_mismatches (out_total_mismatches),
    .out_bin_count        (out_bin_count)
  );

endmodule
